// ----- sv/wep_pkg.sv -----
`default_nettype none
package wep_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned NFLOOR_W    = 15;
  localparam int unsigned THRESH_W    = 16;
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned CNT_W       = 2;
  localparam int unsigned QDEPTH      = 4;

  localparam int unsigned DEF_MAX_FRAME = 65536;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [NFLOOR_W-1:0] NFLOOR_RST = NFLOOR_W'(1);
  localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(49);

  typedef enum logic [0:0] {
    REG_NOISE_FLOOR = 1'b0,
    REG_THRESHOLD   = 1'b1
  } reg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_START     = 3'd0,
    KIND_SIL_START = 3'd1,
    KIND_SIL_END   = 3'd2,
    KIND_MIN       = 3'd3,
    KIND_MAX       = 3'd4,
    KIND_END       = 3'd5
  } point_kind_e;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    point_kind_e      kind;
  } point_t;

  // up to three points raised by one input word, slot 0 goes out first
  typedef struct packed {
    logic [CNT_W-1:0]             cnt;
    point_t [MAX_RESULTS-1:0]     pt;
  } job_t;

endpackage
`default_nettype wire

// ----- sv/wep_if.sv -----
`default_nettype none
interface wep_in_if;
  import wep_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_end;

  modport source (output valid, sample, frame_end, input ready);
  modport sink (input valid, sample, frame_end, output ready);
endinterface

interface wep_out_if;
  import wep_pkg::*;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  point_index;
  logic [KIND_W-1:0] point_kind;
  logic              last;

  modport source (output valid, point_index, point_kind, last, input ready);
  modport sink (input valid, point_index, point_kind, last, output ready);
endinterface
`default_nettype wire

// ----- sv/wep_front.sv -----
`default_nettype none
module wep_front #(
  parameter int unsigned MAX_FRAME = wep_pkg::DEF_MAX_FRAME
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [wep_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                frame_end_i,
  input  wire logic [wep_pkg::NFLOOR_W-1:0]        noise_floor_i,
  input  wire logic [wep_pkg::THRESH_W-1:0]        threshold_i,
  input  wire logic                                q_full_i,
  output logic                                     job_valid_o,
  output wep_pkg::job_t                            job_o
);
  import wep_pkg::*;

  localparam int unsigned PW = $clog2(MAX_FRAME);

  logic signed [SAMPLE_W-1:0] older_q, older_d;
  logic signed [SAMPLE_W-1:0] newer_q, newer_d;
  logic [PW-1:0]              pos_q, pos_d;
  logic                       sil_q, sil_d;

  logic                accept;
  logic                win;
  logic                quiet;
  logic                is_min;
  logic                is_max;
  logic signed [16:0]  l17, m17, r17;
  logic signed [16:0]  d_lm, d_rm, d_ml, d_mr;
  logic signed [17:0]  thr18;
  logic [16:0]         mag;
  logic [PW-1:0]       p, p_m1, p_p1;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign win  = (pos_q >= PW'(3));
  assign p    = pos_q - PW'(2);
  assign p_m1 = pos_q - PW'(3);
  assign p_p1 = pos_q - PW'(1);

  assign l17  = 17'(older_q);
  assign m17  = 17'(newer_q);
  assign r17  = 17'(sample_i);
  assign d_lm = l17 - m17;
  assign d_rm = r17 - m17;
  assign d_ml = m17 - l17;
  assign d_mr = m17 - r17;
  assign thr18 = $signed({2'b00, threshold_i});
  assign mag   = l17[16] ? 17'(-l17) : 17'(l17);
  assign quiet = mag < {2'b00, noise_floor_i};

  assign is_min = (18'(d_lm) > thr18) && (18'(d_rm) > thr18);
  assign is_max = (18'(d_ml) > thr18) && (18'(d_mr) > thr18);

  always_comb begin
    logic [CNT_W-1:0] n;
    n     = '0;
    job_o = '0;
    sil_d = sil_q;

    if (pos_q == '0) begin
      job_o.pt[n] = '{idx: '0, kind: KIND_START};
      n = n + 1'b1;
    end

    if (win) begin
      if (quiet) begin
        if (!sil_q) begin
          job_o.pt[n] = '{idx: IDX_W'(p), kind: KIND_SIL_START};
          n = n + 1'b1;
          sil_d = 1'b1;
        end
      end else begin
        if (sil_q) begin
          job_o.pt[n] = '{idx: IDX_W'(p_m1), kind: KIND_SIL_END};
          n = n + 1'b1;
          sil_d = 1'b0;
        end
        // vertex lands on p when it leans toward the left neighbor
        if (is_min) begin
          job_o.pt[n] = '{idx: (l17 < r17) ? IDX_W'(p) : IDX_W'(p_p1), kind: KIND_MIN};
          n = n + 1'b1;
        end else if (is_max) begin
          job_o.pt[n] = '{idx: (l17 > r17) ? IDX_W'(p) : IDX_W'(p_p1), kind: KIND_MAX};
          n = n + 1'b1;
        end
      end
    end

    if (frame_end_i) begin
      if (sil_d && win) begin
        job_o.pt[n] = '{idx: IDX_W'(p), kind: KIND_SIL_END};
        n = n + 1'b1;
      end
      job_o.pt[n] = '{idx: IDX_W'(pos_q), kind: KIND_END};
      n = n + 1'b1;
      sil_d = 1'b0;
    end

    job_o.cnt = n;
  end

  assign job_valid_o = accept && (job_o.cnt != '0);

  always_comb begin
    older_d = newer_q;
    newer_d = sample_i;
    pos_d   = pos_q;
    if (frame_end_i) begin
      older_d = '0;
      newer_d = '0;
      pos_d   = '0;
    end else if (pos_q < PW'(MAX_FRAME - 1)) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      pos_q   <= '0;
      sil_q   <= 1'b0;
    end else if (accept) begin
      older_q <= older_d;
      newer_q <= newer_d;
      pos_q   <= pos_d;
      sil_q   <= sil_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/wep_queue.sv -----
`default_nettype none
module wep_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire wep_pkg::job_t push_data_i,
  output logic               full_o,
  output logic               head_valid_o,
  output wep_pkg::job_t      head_o,
  input  wire logic          pop_i
);
  import wep_pkg::*;

  localparam int unsigned AW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  job_t          mem_q [QDEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
    return (ptr == AW'(QDEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full_o       = (cnt_q == CW'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/wep_back.sv -----
`default_nettype none
module wep_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     head_valid_i,
  input  wire wep_pkg::job_t            head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [wep_pkg::IDX_W-1:0]     point_index_o,
  output wep_pkg::point_kind_e          point_kind_o,
  output logic                          last_o
);
  import wep_pkg::*;

  logic [CNT_W-1:0] sub_q, sub_d;
  logic             valid_q, valid_d;
  point_t           pt_q;
  logic             last_q;
  logic             load;
  logic             final_pt;

  assign load     = head_valid_i && (!valid_q || out_ready_i);
  assign final_pt = (sub_q == head_i.cnt - 1'b1);
  assign pop_o    = load && final_pt;

  always_comb begin
    sub_d   = sub_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      sub_d   = final_pt ? '0 : sub_q + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      sub_q   <= sub_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pt_q   <= head_i.pt[sub_q];
      last_q <= final_pt;
    end
  end

  assign out_valid_o   = valid_q;
  assign point_index_o = pt_q.idx;
  assign point_kind_o  = pt_q.kind;
  assign last_o        = last_q;

endmodule
`default_nettype wire

// ----- sv/waveform_extrema_picker_unit.sv -----
// Waveform extrema picker.
// in_ch (sink): one Q1.15 sample per word, frame_end on the last sample of a frame.
// out_ch (source): points to draw: index, kind (start, silence start/end, min, max,
// end) and last, set on the final point raised by an input word.
// APB port: register 0 noise_floor (15 bit), register 1 extremum_threshold (16 bit),
// byte addresses 0 and 4; the user must see they are written only while the block
// is idle, as the block itself leaves this unchecked. Throughput: one sample per
// cycle while in_ch.ready is high. Each sample turns into 0..3 points in the front
// stage and the job is queued (4 entries); the back stage drains one point per cycle
// while out_ch.ready is high, so the single output register sets the rate. A sample's
// points pass the job queue, then the output register; the window for position p is
// judged when sample p+2 arrives. Output stall: points hold in the output register,
// the queue fills, and in_ch.ready drops only once the queue is full.
// Reset: frame position, sample history, silence flag and queue are cleared;
// registers return to noise_floor 1 and extremum_threshold 49.
`default_nettype none
module waveform_extrema_picker_unit #(
  parameter int unsigned MAX_FRAME = wep_pkg::DEF_MAX_FRAME
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  wep_in_if.sink                             in_ch,
  wep_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wep_pkg::APB_AW-1:0]    paddr,
  input  wire logic [wep_pkg::APB_DW-1:0]    pwdata,
  output logic [wep_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import wep_pkg::*;

  logic [NFLOOR_W-1:0] nfloor_q;
  logic [THRESH_W-1:0] thresh_q;
  logic                cfg_wr;
  reg_idx_e            reg_sel;

  logic        q_full;
  logic        job_valid;
  job_t        job;
  logic        head_valid;
  job_t        head;
  logic        pop;
  point_kind_e kind;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nfloor_q <= NFLOOR_RST;
      thresh_q <= THRESH_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_NOISE_FLOOR: nfloor_q <= pwdata[NFLOOR_W-1:0];
        REG_THRESHOLD:   thresh_q <= pwdata[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NOISE_FLOOR: prdata = APB_DW'(nfloor_q);
      REG_THRESHOLD:   prdata = APB_DW'(thresh_q);
      default:         prdata = '0;
    endcase
  end

  wep_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_ch.valid),
    .in_ready_o    (in_ch.ready),
    .sample_i      (in_ch.sample),
    .frame_end_i   (in_ch.frame_end),
    .noise_floor_i (nfloor_q),
    .threshold_i   (thresh_q),
    .q_full_i      (q_full),
    .job_valid_o   (job_valid),
    .job_o         (job)
  );

  wep_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_valid),
    .push_data_i  (job),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  wep_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .point_index_o (out_ch.point_index),
    .point_kind_o  (kind),
    .last_o        (out_ch.last)
  );

  assign out_ch.point_kind = kind;

endmodule
`default_nettype wire

// ----- tb/wep_point_checker.sv -----
`default_nettype none
module wep_point_checker #(
  parameter int unsigned MAX_FRAME = wep_pkg::DEF_MAX_FRAME
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  wep_in_if                          in_ch,
  wep_out_if                         out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wep_pkg::APB_AW-1:0] paddr,
  input  logic [wep_pkg::APB_DW-1:0] pwdata,
  input  logic [wep_pkg::APB_DW-1:0] prdata,
  input  logic                       pready,
  output int unsigned                bad_count_o,
  output int unsigned                pending_o,
  output int unsigned                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wep_pkg::*;

  localparam logic [APB_AW-1:0] FLOOR_ADDR  = {REG_NOISE_FLOOR, 2'b00};
  localparam logic [APB_AW-1:0] THRESH_ADDR = {REG_THRESHOLD, 2'b00};

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    point_kind_e      kind;
    logic             last;
  } due_point_t;

  due_point_t due_points[$];
  due_point_t want;

  // shadow of the block: registers and frame history
  logic [NFLOOR_W-1:0]        nfloor;
  logic [THRESH_W-1:0]        thresh;
  logic signed [SAMPLE_W-1:0] older_smp;
  logic signed [SAMPLE_W-1:0] newer_smp;
  int unsigned                position;
  logic                       silent;

  task automatic flag_field(input string field, input logic [31:0] exp_v,
                            input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      bad_count_o++;
      $error("%s mismatch: expected %0d, got %0d", field, exp_v, got_v);
    end
  endtask

  task automatic note_point(input int idx, input point_kind_e kind);
    due_points.push_back('{IDX_W'(idx), kind, 1'b0});
  endtask

  // points raised by one sample word; window for p = n-2 is judged as sample n arrives
  task automatic pick_points(input int s, input logic fe);
    int unsigned n;
    int unsigned start_size;
    int          p;
    int          l;
    int          m;
    int          mag;
    int          thr;
    n = position;
    start_size = due_points.size();
    if (n == 0) note_point(0, KIND_START);
    if (n >= 3) begin
      p = int'(n) - 2;
      l = older_smp;
      m = newer_smp;
      mag = (l < 0) ? -l : l;
      thr = int'(thresh);
      if (mag < int'(nfloor)) begin
        if (!silent) begin
          note_point(p, KIND_SIL_START);
          silent = 1'b1;
        end
      end else begin
        if (silent) begin
          note_point(p - 1, KIND_SIL_END);
          silent = 1'b0;
        end
        // vertex offset sign decides between p and p+1
        if (l - m > thr && s - m > thr) note_point((l < s) ? p : p + 1, KIND_MIN);
        else if (m - l > thr && m - s > thr) note_point((l > s) ? p : p + 1, KIND_MAX);
      end
    end
    older_smp = newer_smp;
    newer_smp = SAMPLE_W'(s);
    if (fe) begin
      if (silent && n >= 3) note_point(int'(n) - 2, KIND_SIL_END);
      note_point(int'(n), KIND_END);
      older_smp = '0;
      newer_smp = '0;
      position = 0;
      silent = 1'b0;
    end else if (n < MAX_FRAME - 1) begin
      position = n + 1;
    end
    if (due_points.size() > start_size) due_points[due_points.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nfloor = NFLOOR_RST;
      thresh = THRESH_RST;
      older_smp = '0;
      newer_smp = '0;
      position = 0;
      silent = 1'b0;
      due_points.delete();
      bad_count_o = 0;
      checked_o = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == FLOOR_ADDR) nfloor = pwdata[NFLOOR_W-1:0];
          else if (paddr == THRESH_ADDR) thresh = pwdata[THRESH_W-1:0];
        end else if (paddr == FLOOR_ADDR) begin
          flag_field("noise_floor readback", APB_DW'(nfloor), prdata);
        end else if (paddr == THRESH_ADDR) begin
          flag_field("extremum_threshold readback", APB_DW'(thresh), prdata);
        end
      end
      if (in_ch.valid && in_ch.ready) pick_points(int'(in_ch.sample), in_ch.frame_end);
      if (out_ch.valid && out_ch.ready) begin
        checked_o++;
        if (due_points.size() == 0) begin
          bad_count_o++;
          $error("point index %0d kind %0d arrived with no point due",
                 out_ch.point_index, out_ch.point_kind);
        end else begin
          want = due_points.pop_front();
          flag_field("point_index", 32'(want.idx), 32'(out_ch.point_index));
          flag_field("point_kind", 32'(want.kind), 32'(out_ch.point_kind));
          flag_field("last", 32'(want.last), 32'(out_ch.last));
        end
      end
    end
    pending_o = due_points.size();
  end

endmodule
`default_nettype wire

// ----- tb/waveform_extrema_picker_unit_test.sv -----
`default_nettype none
module waveform_extrema_picker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wep_pkg::*;

  localparam int unsigned MAX_FRAME   = DEF_MAX_FRAME;
  localparam int unsigned IDLE_PCT    = 16;
  localparam int unsigned PHASE_WORDS = 18;
  localparam int unsigned CALM_WORDS  = 40;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned DRAIN_LIMIT = 5000;

  typedef enum int unsigned {
    STYLE_NOISE,
    STYLE_WALK,
    STYLE_QUIET,
    STYLE_EDGE
  } wave_style_e;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned bad_count;
  int unsigned pending;
  int unsigned checked;

  bit          calm;
  int unsigned cur_floor;
  int unsigned cur_thresh;
  int unsigned samples_sent;
  int unsigned frames_sent;
  int unsigned settings_seen;
  int unsigned floor_set[NUM_PHASES];
  int unsigned thresh_set[NUM_PHASES];

  wep_in_if  in_ch();
  wep_out_if out_ch();

  waveform_extrema_picker_unit #(.MAX_FRAME(MAX_FRAME)) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  wep_point_checker #(.MAX_FRAME(MAX_FRAME)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .bad_count_o (bad_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  initial begin
    #10_000_000;
    $display("waveform_extrema_picker_unit regression: fail");
    $finish;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic wave_style_e pick_style();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return STYLE_NOISE;
    if (r < 7) return STYLE_WALK;
    if (r < 9) return STYLE_QUIET;
    return STYLE_EDGE;
  endfunction

  function automatic int next_sample(input wave_style_e style, input int prev);
    logic signed [SAMPLE_W-1:0] w;
    int                         v;
    int                         span;
    case (style)
      STYLE_NOISE: begin
        w = SAMPLE_W'($urandom);
        v = int'(w);
      end
      STYLE_WALK: begin
        // steps around twice the threshold, so turns often clear it
        span = 2 * int'(cur_thresh) + 100;
        if (span > 30000) span = 30000;
        v = prev + int'($urandom_range(0, 2 * span)) - span;
      end
      STYLE_QUIET: begin
        if (cur_floor > 0 && $urandom_range(0, 3) != 0)
          v = int'($urandom_range(0, cur_floor - 1));
        else
          v = int'(cur_floor) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: begin
        case ($urandom_range(0, 7))
          0: v = -32768;
          1: v = 32767;
          2: v = -32767;
          3: v = 0;
          4: v = 1;
          5: v = -1;
          6: v = int'(cur_floor);
          default: v = -int'(cur_floor);
        endcase
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic push_word(input int v, input bit fe);
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= SAMPLE_W'(v);
    in_ch.frame_end <= fe;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    samples_sent++;
    if (fe) frames_sent++;
  endtask

  task automatic send_frame(input int vals[$]);
    foreach (vals[k]) push_word(vals[k], k == vals.size() - 1);
  endtask

  task automatic random_phase(input int unsigned min_words);
    int unsigned sent;
    int unsigned len;
    wave_style_e style;
    int          prev;
    sent = 0;
    while (sent < min_words) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      style = pick_style();
      prev = 0;
      for (int unsigned k = 0; k < len; k++) begin
        if ($urandom_range(0, 5) == 0) style = pick_style();
        prev = next_sample(style, prev);
        push_word(prev, k == len - 1);
      end
      sent += len;
    end
  endtask

  // wait for the last point, then hold the input idle while the block settles
  task automatic drain(input int unsigned settle);
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic apb_access(input reg_idx_e idx, input bit wr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // junk above the register width must be dropped by the block
  task automatic set_levels(input int unsigned nfloor, input int unsigned thr);
    logic [APB_DW-1:0] word;
    word = APB_DW'(nfloor);
    if ($urandom_range(0, 1) != 0) word |= APB_DW'($urandom) << NFLOOR_W;
    apb_access(REG_NOISE_FLOOR, 1'b1, word);
    word = APB_DW'(thr);
    if ($urandom_range(0, 1) != 0) word |= APB_DW'($urandom) << THRESH_W;
    apb_access(REG_THRESHOLD, 1'b1, word);
    apb_access(REG_NOISE_FLOOR, 1'b0, '0);
    apb_access(REG_THRESHOLD, 1'b0, '0);
    cur_floor = nfloor;
    cur_thresh = thr;
    settings_seen++;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.sample    <= '0;
    in_ch.frame_end <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    calm = 1'b0;
    cur_floor = 1;
    cur_thresh = 49;
    samples_sent = 0;
    frames_sent = 0;
    settings_seen = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset levels read back, then short frames, vertex cases and silence runs
    apb_access(REG_NOISE_FLOOR, 1'b0, '0);
    apb_access(REG_THRESHOLD, 1'b0, '0);
    send_frame('{32767});
    send_frame('{-32768, 0});
    send_frame('{5, -5, 9});
    send_frame('{0, -1000, -3000, 500});
    send_frame('{100, 0, 0, 0, 32767, -32768, 32767, -100, 200, -300, 0});
    send_frame('{0, 0, 0, 0});
    drain(SETTLE);

    floor_set  = '{0, 32767, 32767, 0, $urandom_range(0, 2000), $urandom_range(1, 32767)};
    thresh_set = '{0, 65535, 0, 65535, $urandom_range(0, 3000), $urandom_range(0, 65535)};
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      set_levels(floor_set[ph], thresh_set[ph]);
      random_phase(PHASE_WORDS);
      drain(SETTLE);
    end

    // a stretch with no gaps on either side
    set_levels(120, 200);
    calm = 1'b1;
    random_phase(CALM_WORDS);
    calm = 1'b0;
    drain(SETTLE);

    if (pending != 0) $error("%0d expected points never arrived", pending);
    $display("covered %0d sample words in %0d frames, short frames and silence runs included",
             samples_sent, frames_sent);
    $display("%0d points checked under %0d register settings", checked, settings_seen);
    if (bad_count == 0 && pending == 0) begin
      $display("waveform_extrema_picker_unit regression: pass");
    end else begin
      $display("waveform_extrema_picker_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- waveform_extrema_picker_unit.f -----
sv/wep_pkg.sv
sv/wep_if.sv
sv/wep_front.sv
sv/wep_queue.sv
sv/wep_back.sv
sv/waveform_extrema_picker_unit.sv
tb/wep_point_checker.sv
tb/waveform_extrema_picker_unit_test.sv
